@@ rtl/utf8_to_utf16_decoder_top_assert.svh @@
// Assertion macros for the UTF-8 to UTF-16 decoder.
`ifndef UTF8_TO_UTF16_DECODER_TOP_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, idle in reset.
`define U2U_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u2u assertion failed");
// Next-cycle implication, sampled on clk, idle in reset.
`define U2U_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u2u assertion failed");
`else
`define U2U_ASSERT_IMP(lbl, ante, cons)
`define U2U_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/u2u_pkg.sv @@
// Shared types and constants of the UTF-8 to UTF-16 decoder.
package u2u_pkg;

    localparam int UNIT_W  = 16;
    localparam int POINT_W = 21;

    typedef enum logic [1:0] {
        STOP_OK       = 2'd0,
        STOP_BAD_LEAD = 2'd1,
        STOP_NO_ROOM  = 2'd2
    } stop_t;

    typedef enum logic {
        KIND_UNIT = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    localparam logic [UNIT_W-1:0] CNT_MAX  = 16'hFFFF;
    localparam logic [UNIT_W-1:0] HI_SURR  = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR  = 16'hDC00;
    localparam logic [9:0]        PLANE_OFS = 10'h040;

    // One queued job: what one input byte produces (one or two results).
    typedef struct packed {
        kind_t             kind;
        logic              pair;
        logic [UNIT_W-1:0] val0;
        logic [UNIT_W-1:0] val1;
        logic [UNIT_W-1:0] cnt0;
        logic [UNIT_W-1:0] cnt1;
        stop_t             status;
    } job_t;

    // One result transaction on the output stream.
    typedef struct packed {
        kind_t             kind;
        logic [UNIT_W-1:0] value;
        logic [UNIT_W-1:0] count;
        stop_t             status;
        logic              last;
    } res_t;

    function automatic logic [UNIT_W-1:0] sat_inc(input logic [UNIT_W-1:0] n);
        sat_inc = (n == CNT_MAX) ? CNT_MAX : n + 16'd1;
    endfunction

endpackage

@@ rtl/utf8_to_utf16_decoder_top.sv @@
// Top level of the UTF-8 to UTF-16 stream decoder.
// Throughput: one input byte per cycle while the job queue has room; a four-byte sequence
//   yields two output transactions (surrogate pair), absorbed by the job queue.
// A result reaches m_tvalid through the job queue and then the back end's output register.
// s_tready falls only when the QUEUE_DEPTH-entry job queue is full.
// Reset (rst_n, async, active low): decoder idle, queue empty, capacity 256, counting off.
`include "utf8_to_utf16_decoder_top_assert.svh"
module utf8_to_utf16_decoder_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] unit_value, [31:16] unit_count,
                                   // [33:32] stop_status, [39:34] zero
    output logic        m_tuser,   // kind
    output logic        m_tlast    // last_of_run
);
    import u2u_pkg::*;

    localparam logic REG_CAPACITY   = 1'b0;
    localparam logic REG_COUNT_ONLY = 1'b1;

    logic [15:0] cap_reg;
    logic        count_only_reg;
    logic        cfg_wr;

    logic        in_accept;
    logic        push;
    job_t        push_job;
    logic        pop;
    job_t        head_job;
    logic        q_empty;
    logic        q_full;
    res_t        out_res;
    logic        pair_pending;

    // Config registers: written in the APB access phase, no wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= 16'd256;
            count_only_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_CAPACITY:   cap_reg        <= pwdata[15:0];
                REG_COUNT_ONLY: count_only_reg <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CAPACITY:   prdata = {16'd0, cap_reg};
            REG_COUNT_ONLY: prdata = {31'd0, count_only_reg};
            default:        prdata = '0;
        endcase
    end

    // Front end decodes one byte per transaction; the queue decouples it
    // from output stalls.
    assign s_tready  = ~q_full;
    assign in_accept = s_tvalid & s_tready;

    u2u_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .in_byte      (s_tdata),
        .out_capacity (cap_reg),
        .count_only   (count_only_reg),
        .push         (push),
        .push_job     (push_job)
    );

    u2u_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Back end splits surrogate pairs into two transactions.
    u2u_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_job     (head_job),
        .empty        (q_empty),
        .pop          (pop),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_res      (out_res),
        .pair_pending (pair_pending)
    );

    assign m_tdata = {6'd0, out_res.status, out_res.count, out_res.value};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

    // A half-sent pair must still have its job at the queue head.
    `U2U_ASSERT_IMP(a_pair_has_job, pair_pending, !q_empty)
    // Terminator results always close the run.
    `U2U_ASSERT_IMP(a_end_is_last, m_tvalid && m_tuser, m_tlast)
    // The only non-final result is a high surrogate.
    `U2U_ASSERT_IMP(a_first_is_high, m_tvalid && !m_tlast,
        !m_tuser && m_tdata[15:10] == 6'b110110)
    // After a high surrogate is taken, the low surrogate follows.
    `U2U_ASSERT_NXT(a_low_follows, m_tvalid && m_tready && !m_tlast,
        m_tvalid && m_tlast && m_tdata[15:10] == 6'b110111)

endmodule

@@ rtl/u2u_front.sv @@
// Front end: accepts UTF-8 bytes, tracks sequence state, queues result jobs.
module u2u_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         in_byte,
    input  logic [15:0]        out_capacity,
    input  logic               count_only,
    output logic               push,
    output u2u_pkg::job_t      push_job
);
    import u2u_pkg::*;

    logic [POINT_W-1:0] point_reg, point_next;
    logic [1:0]         pend_reg, pend_next;
    logic               four_reg, four_next;
    stop_t              stop_reg, stop_next;
    logic [UNIT_W-1:0]  done_reg, done_next;

    logic               is1, is2, is3, is4;
    logic [16:0]        room_diff;
    logic               room_short;
    logic [POINT_W-1:0] cont_point;
    logic [UNIT_W-1:0]  c1, c2;

    assign is1 = ~in_byte[7];
    assign is2 = in_byte[7:5] == 3'b110;
    assign is3 = in_byte[7:4] == 4'b1110;
    assign is4 = in_byte[7:3] == 5'b11110;

    // free slots = capacity - done; a borrow into bit 16 means no room
    assign room_diff  = {1'b0, out_capacity} - {1'b0, done_reg};
    assign room_short = room_diff[16] || (room_diff[15:0] < (is4 ? 16'd3 : 16'd2));

    assign cont_point = {point_reg[POINT_W-7:0], in_byte[5:0]};
    assign c1 = sat_inc(done_reg);
    assign c2 = sat_inc(c1);

    always_comb
    begin
        point_next = point_reg;
        pend_next  = pend_reg;
        four_next  = four_reg;
        stop_next  = stop_reg;
        done_next  = done_reg;
        push       = 1'b0;
        push_job   = '0;
        if (accept)
        begin
            priority if (in_byte == 8'd0)
            begin
                push            = 1'b1;
                push_job.kind   = KIND_END;
                push_job.cnt0   = done_reg;
                push_job.status = stop_reg;
                point_next      = '0;
                pend_next       = 2'd0;
                four_next       = 1'b0;
                stop_next       = STOP_OK;
                done_next       = '0;
            end
            else if (stop_reg != STOP_OK)
            begin
                // stopped: ignore until terminator
            end
            else if (pend_reg != 2'd0)
            begin
                point_next = cont_point;
                pend_next  = pend_reg - 2'd1;
                if (pend_reg == 2'd1)
                begin
                    point_next    = '0;
                    four_next     = 1'b0;
                    push          = ~count_only;
                    push_job.kind = KIND_UNIT;
                    push_job.cnt0 = c1;
                    push_job.cnt1 = c2;
                    if (four_reg)
                    begin
                        done_next     = c2;
                        push_job.pair = 1'b1;
                        push_job.val0 = HI_SURR | {6'd0, cont_point[19:10] - PLANE_OFS};
                        push_job.val1 = LO_SURR | {6'd0, cont_point[9:0]};
                    end
                    else
                    begin
                        done_next     = c1;
                        push_job.val0 = cont_point[UNIT_W-1:0];
                    end
                end
            end
            else if (!(is1 || is2 || is3 || is4))
            begin
                stop_next = STOP_BAD_LEAD;
            end
            else if (!count_only && room_short)
            begin
                stop_next = STOP_NO_ROOM;
            end
            else if (is1)
            begin
                done_next     = c1;
                four_next     = 1'b0;
                push          = ~count_only;
                push_job.kind = KIND_UNIT;
                push_job.val0 = {9'd0, in_byte[6:0]};
                push_job.cnt0 = c1;
            end
            else if (is2)
            begin
                point_next = {16'd0, in_byte[4:0]};
                pend_next  = 2'd1;
                four_next  = 1'b0;
            end
            else if (is3)
            begin
                point_next = {17'd0, in_byte[3:0]};
                pend_next  = 2'd2;
                four_next  = 1'b0;
            end
            else
            begin
                point_next = {18'd0, in_byte[2:0]};
                pend_next  = 2'd3;
                four_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_reg <= '0;
            pend_reg  <= 2'd0;
            four_reg  <= 1'b0;
            stop_reg  <= STOP_OK;
            done_reg  <= '0;
        end
        else
        begin
            point_reg <= point_next;
            pend_reg  <= pend_next;
            four_reg  <= four_next;
            stop_reg  <= stop_next;
            done_reg  <= done_next;
        end
    end

endmodule

@@ rtl/u2u_queue.sv @@
// Small job queue between front end and back end.
module u2u_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  u2u_pkg::job_t push_job,
    input  logic          pop,
    output u2u_pkg::job_t head_job,
    output logic          empty,
    output logic          full
);
    import u2u_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign empty    = cnt_reg == '0;
    assign full     = cnt_reg == CW'(DEPTH);
    assign head_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/u2u_back.sv @@
// Back end: expands queued jobs into result transactions via an output register.
module u2u_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  u2u_pkg::job_t head_job,
    input  logic          empty,
    output logic          pop,
    input  logic          out_ready,
    output logic          out_valid,
    output u2u_pkg::res_t out_res,
    output logic          pair_pending
);
    import u2u_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg, res_next;
    logic phase_reg, phase_next;
    logic load;

    assign load = ~valid_reg | out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        phase_next = phase_reg;
        pop        = 1'b0;
        if (load)
        begin
            priority if (phase_reg)
            begin
                // low surrogate of a pair
                valid_next     = 1'b1;
                res_next.kind  = KIND_UNIT;
                res_next.value = head_job.val1;
                res_next.count = head_job.cnt1;
                res_next.status = STOP_OK;
                res_next.last  = 1'b1;
                phase_next     = 1'b0;
                pop            = 1'b1;
            end
            else if (!empty)
            begin
                valid_next      = 1'b1;
                res_next.kind   = head_job.kind;
                res_next.value  = head_job.val0;
                res_next.count  = head_job.cnt0;
                res_next.status = head_job.status;
                res_next.last   = ~head_job.pair;
                phase_next      = head_job.pair;
                pop             = ~head_job.pair;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid    = valid_reg;
    assign out_res      = res_reg;
    assign pair_pending = phase_reg;

endmodule
